// ===== rtl/ffp_pkg.sv =====
// shared types and constants of the fixed frame parser with sum check
package ffp_pkg;

    // field and bus widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned APB_DW  = 32;
    localparam int unsigned APB_AW  = 3;
    localparam int unsigned SUM_W   = 10;
    localparam int unsigned CHECK_W = 16;

    // register word indexes (byte address 4*index)
    localparam logic REG_HEADER = 1'b0;
    localparam logic REG_FOOTER = 1'b1;

    // register reset values
    localparam logic [BYTE_W-1:0] HEADER_RST = 8'hFF;
    localparam logic [BYTE_W-1:0] FOOTER_RST = 8'hFE;

    // parser phase, one-hot
    typedef enum logic [7:0] {
        PH_HUNT   = 8'b0000_0001,
        PH_CID    = 8'b0000_0010,
        PH_HEALTH = 8'b0000_0100,
        PH_PID    = 8'b0000_1000,
        PH_MSG    = 8'b0001_0000,
        PH_FOOTER = 8'b0010_0000,
        PH_CHK_HI = 8'b0100_0000,
        PH_CHK_LO = 8'b1000_0000
    } t_phase;

    // configuration seen by the parser
    typedef struct packed {
        logic [BYTE_W-1:0] header_byte;
        logic [BYTE_W-1:0] footer_byte;
    } t_cfg;

    // one verified frame
    typedef struct packed {
        logic [BYTE_W-1:0] chassis_id;
        logic [BYTE_W-1:0] chassis_health;
        logic [BYTE_W-1:0] payload_id;
        logic [BYTE_W-1:0] payload_msg;
    } t_result;

endpackage

// ===== rtl/fixed_frame_parser_sum_check.sv =====
// top level of the fixed frame parser with sum check
//
// Input channel (i_valid / o_ready / i_rx_byte) takes one received byte per
// item. A frame is header, chassis id, health, payload id, message, footer,
// checksum high, checksum low. The checksum is the 16-bit sum of header,
// payload id, message and footer. A wrong footer sends the parser back to
// hunting without testing that byte as a header; a bad checksum drops the
// frame without a result.
// Output channel (o_valid / i_ready) carries one item of four captured
// fields per verified frame.
// Input rate: one byte per cycle while o_ready is high. A verified result
// is registered into the output register, or the skid stage while one waits.
// The output register has a skid stage behind it; o_ready falls only when
// both hold results, i.e. when the receiver has stalled long enough for a
// second result to arrive, and rises again as soon as one is taken.
// Reset (i_rst_n low, synchronous) empties the output, puts the parser to
// hunting and loads header 0xFF and footer 0xFE. Registers over APB:
// header_byte at 0x0, footer_byte at 0x4.
module fixed_frame_parser_sum_check (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ffp_pkg::BYTE_W-1:0]    i_rx_byte,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ffp_pkg::BYTE_W-1:0]    o_chassis_id,
    output logic [ffp_pkg::BYTE_W-1:0]    o_chassis_health,
    output logic [ffp_pkg::BYTE_W-1:0]    o_payload_id,
    output logic [ffp_pkg::BYTE_W-1:0]    o_payload_msg,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ffp_pkg::APB_AW-1:0]    paddr,
    input  logic [ffp_pkg::APB_DW-1:0]    pwdata,
    output logic [ffp_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    ffp_pkg::t_cfg       cfg;
    ffp_pkg::t_result    parsed;
    ffp_pkg::t_result    out_item;
    logic                take;
    logic                push;
    logic                space;

    assign o_ready = space;
    assign take    = i_valid & space;

    // configuration registers
    ffp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // frame parser
    ffp_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (cfg),
        .o_push    (push),
        .o_result  (parsed)
    );

    // result register and skid
    ffp_out_buf u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (parsed),
        .o_space  (space),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_item)
    );

    assign o_chassis_id     = out_item.chassis_id;
    assign o_chassis_health = out_item.chassis_health;
    assign o_payload_id     = out_item.payload_id;
    assign o_payload_msg    = out_item.payload_msg;

endmodule

// ===== rtl/ffp_cfg_regs.sv =====
// apb register file holding the header and footer byte values
module ffp_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ffp_pkg::APB_AW-1:0]       paddr,
    input  logic [ffp_pkg::APB_DW-1:0]       pwdata,
    output logic [ffp_pkg::APB_DW-1:0]       prdata,
    output logic                             pready,
    output ffp_pkg::t_cfg                    o_cfg
);

    logic                          wr_en;
    logic                          reg_sel;
    logic [ffp_pkg::BYTE_W-1:0]    r_header;
    logic [ffp_pkg::BYTE_W-1:0]    r_footer;
    logic [ffp_pkg::BYTE_W-1:0]    rd_byte;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= ffp_pkg::HEADER_RST;
            r_footer <= ffp_pkg::FOOTER_RST;
        end else if (wr_en) begin
            unique case (reg_sel)
                ffp_pkg::REG_HEADER: r_header <= pwdata[ffp_pkg::BYTE_W-1:0];
                ffp_pkg::REG_FOOTER: r_footer <= pwdata[ffp_pkg::BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_sel)
            ffp_pkg::REG_HEADER: rd_byte = r_header;
            ffp_pkg::REG_FOOTER: rd_byte = r_footer;
            default:             rd_byte = r_header;
        endcase
    end

    assign prdata = {{(ffp_pkg::APB_DW - ffp_pkg::BYTE_W){1'b0}}, rd_byte};

    assign o_cfg.header_byte = r_header;
    assign o_cfg.footer_byte = r_footer;

endmodule

// ===== rtl/ffp_parser.sv =====
// frame parser state machine, field capture and checksum compare
module ffp_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic [ffp_pkg::BYTE_W-1:0]    i_rx_byte,
    input  ffp_pkg::t_cfg                 i_cfg,
    output logic                          o_push,
    output ffp_pkg::t_result              o_result
);

    ffp_pkg::t_phase               r_phase;
    ffp_pkg::t_phase               n_phase;
    logic [ffp_pkg::BYTE_W-1:0]    r_cid;
    logic [ffp_pkg::BYTE_W-1:0]    r_health;
    logic [ffp_pkg::BYTE_W-1:0]    r_pid;
    logic [ffp_pkg::BYTE_W-1:0]    r_msg;
    logic [ffp_pkg::BYTE_W-1:0]    r_chk_hi;
    logic [ffp_pkg::SUM_W-1:0]     frame_sum;
    logic [ffp_pkg::CHECK_W-1:0]   got_sum;
    logic                          sum_ok;

    // expected checksum: header + payload id + message + footer
    assign frame_sum = {2'b00, i_cfg.header_byte} + {2'b00, r_pid}
                     + {2'b00, r_msg} + {2'b00, i_cfg.footer_byte};
    assign got_sum   = {r_chk_hi, i_rx_byte};
    assign sum_ok    = got_sum ==
                       {{(ffp_pkg::CHECK_W - ffp_pkg::SUM_W){1'b0}}, frame_sum};

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_take) begin
            unique case (r_phase)
                ffp_pkg::PH_HUNT:   n_phase = (i_rx_byte == i_cfg.header_byte)
                                              ? ffp_pkg::PH_CID : ffp_pkg::PH_HUNT;
                ffp_pkg::PH_CID:    n_phase = ffp_pkg::PH_HEALTH;
                ffp_pkg::PH_HEALTH: n_phase = ffp_pkg::PH_PID;
                ffp_pkg::PH_PID:    n_phase = ffp_pkg::PH_MSG;
                ffp_pkg::PH_MSG:    n_phase = ffp_pkg::PH_FOOTER;
                ffp_pkg::PH_FOOTER: n_phase = (i_rx_byte == i_cfg.footer_byte)
                                              ? ffp_pkg::PH_CHK_HI : ffp_pkg::PH_HUNT;
                ffp_pkg::PH_CHK_HI: n_phase = ffp_pkg::PH_CHK_LO;
                ffp_pkg::PH_CHK_LO: n_phase = ffp_pkg::PH_HUNT;
                default:            n_phase = ffp_pkg::PH_HUNT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ffp_pkg::PH_HUNT;
        end else begin
            r_phase <= n_phase;
        end
    end

    // field capture: chassis id, health, payload id, message and checksum high byte
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            if (r_phase == ffp_pkg::PH_CID)    r_cid    <= i_rx_byte;
            if (r_phase == ffp_pkg::PH_HEALTH) r_health <= i_rx_byte;
            if (r_phase == ffp_pkg::PH_PID)    r_pid    <= i_rx_byte;
            if (r_phase == ffp_pkg::PH_MSG)    r_msg    <= i_rx_byte;
            if (r_phase == ffp_pkg::PH_CHK_HI) r_chk_hi <= i_rx_byte;
        end
    end

    // a result on the checksum low byte when the sum matches
    assign o_push = i_take & (r_phase == ffp_pkg::PH_CHK_LO) & sum_ok;
    assign o_result.chassis_id     = r_cid;
    assign o_result.chassis_health = r_health;
    assign o_result.payload_id     = r_pid;
    assign o_result.payload_msg    = r_msg;

    // a result always leaves the parser hunting
    a_push_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> r_phase == ffp_pkg::PH_HUNT)
        else $error("parser not hunting after a result");

    // a frame start follows only a header match while hunting
    a_start_on_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && r_phase == ffp_pkg::PH_HUNT && i_rx_byte != i_cfg.header_byte)
        |=> r_phase == ffp_pkg::PH_HUNT)
        else $error("frame started without a header byte");

    // the phase only moves on an accepted item
    a_phase_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_take |=> $stable(r_phase))
        else $error("phase moved without an item");

endmodule

// ===== rtl/ffp_out_buf.sv =====
// two-entry output register with skid stage for verified frames
module ffp_out_buf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  ffp_pkg::t_result     i_result,
    output logic                 o_space,
    output logic                 o_valid,
    input  logic                 i_ready,
    output ffp_pkg::t_result     o_result
);

    logic                 r_main_valid;
    logic                 n_main_valid;
    logic                 r_skid_valid;
    logic                 n_skid_valid;
    ffp_pkg::t_result     r_main;
    ffp_pkg::t_result     n_main;
    ffp_pkg::t_result     r_skid;
    ffp_pkg::t_result     n_skid;
    logic                 pop;

    assign pop     = r_main_valid & i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_result = r_main;

    // keep items in order: main, then skid, then the new one
    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        priority if (r_skid_valid && pop) begin
            n_main       = r_skid;
            n_main_valid = 1'b1;
            n_skid       = i_result;
            n_skid_valid = i_push;
        end else if (!r_main_valid || pop) begin
            n_main       = i_result;
            n_main_valid = i_push;
            n_skid_valid = 1'b0;
        end else if (i_push) begin
            n_skid       = i_result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    // skid only holds an item behind a waiting main item
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid item without a main item");

    // no item arrives while the skid stage is full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("item pushed into a full buffer");

    // a stalled result stays put
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_main_valid && !i_ready) |=> (r_main_valid && $stable(r_main)))
        else $error("result changed while stalled");

endmodule
